FILE: sv/free_block_bitmap_allocator_macros.svh
// Assertion macros shared by the free block bitmap allocator RTL.
`ifndef FREE_BLOCK_BITMAP_ALLOCATOR_MACROS_SVH
`define FREE_BLOCK_BITMAP_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define FBBA_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("fbba: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define FBBA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("fbba: next-cycle check failed");

`else

`define FBBA_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define FBBA_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

FILE: sv/fbba_pkg.sv
// Package with sizes, request codes, types and helper functions of the allocator.
package fbba_pkg;

    // Map geometry. Only blocks that a 12-bit index can name are stored.
    localparam int BLOCK_COUNT     = 4096;
    localparam int INDEX_W         = 12;
    localparam int INDEX_LIMIT     = 2 ** INDEX_W;
    localparam int MAP_BLOCKS      = (BLOCK_COUNT < INDEX_LIMIT) ? BLOCK_COUNT : INDEX_LIMIT;
    localparam int WORD_W          = 32;
    localparam int BIT_W           = 5;
    localparam int NUM_WORDS       = (MAP_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int HINT_W          = $clog2(NUM_WORDS + 1);
    // Blocks below this number are in use after reset.
    localparam int RESERVED_BLOCKS = 10;

    // Request codes; code 3 behaves as a check.
    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_CHECK  = 2'd1;
    localparam logic [1:0] REQ_TOGGLE = 2'd2;

    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [WADDR_W-1:0] waddr_t;
    typedef logic [HINT_W-1:0]  hint_t;
    typedef logic [BIT_W-1:0]   bitpos_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Contents of a map word after reset. Block 32*a+j sits at bit 31-j.
    function automatic word_t reset_word(input waddr_t addr);
        int    blk;
        word_t w;
        w = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            blk = int'(addr) * WORD_W + j;
            w[WORD_W-1-j] = (blk >= RESERVED_BLOCKS) && (blk < MAP_BLOCKS);
        end
        return w;
    endfunction

    // Offset of the lowest-numbered free block in a word (MSB first).
    function automatic bitpos_t first_free(input word_t w);
        bitpos_t pos;
        pos = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (w[WORD_W-1-j])
            begin
                pos = bitpos_t'(j);
            end
        end
        return pos;
    endfunction

endpackage

FILE: sv/fbba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module fbba_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: sv/free_block_bitmap_allocator.sv
// Top level of the free block bitmap allocator: sequencer, word scan unit and valid bits.
//
// Channel   Direction  Handshake            Word
// request   in         start && !busy       req_type, block_index
// result    out        done (one cycle)     result_block, is_free, status
//
// Check and toggle pass through a single scan state before busy falls; the result strobe follows in the next cycle.
// Allocate reads one 32-bit map word per cycle, starting at the lowest word that may still
// hold a free block, and stays busy until it finds one or reaches the last word.
// After reset the map reads as its initial contents at once: per-word valid bits stand in
// for words never written, so no clearing pass is needed.
// The receiver cannot stall; a new word may be accepted in the cycle that done is high.
`include "free_block_bitmap_allocator_macros.svh"

module free_block_bitmap_allocator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       req_type,
    input  fbba_pkg::index_t block_index,
    output logic             busy,
    output logic             done,
    output fbba_pkg::index_t result_block,
    output logic             is_free,
    output logic             status
);

    import fbba_pkg::*;

    state_t  state_reg, state_next;
    hint_t   hint_reg, hint_next;
    logic    done_reg, done_next;
    logic    rd_valid_reg;
    logic    valid_reg [NUM_WORDS];

    logic [1:0] req_reg, req_next;
    index_t  idx_reg, idx_next;
    waddr_t  addr_reg, addr_next;
    index_t  result_reg, result_next;
    logic    free_reg, free_next;
    logic    status_reg, status_next;

    waddr_t  rd_addr;
    word_t   rd_data;
    logic    wr_en;
    word_t   wr_data;

    word_t   word_cur;
    logic    in_range;
    bitpos_t bit_sel;
    logic    cur_bit;
    bitpos_t free_pos;
    logic    word_any;
    logic    last_word;
    logic    hint_full;
    word_t   toggle_mask;
    word_t   alloc_mask;

    // Map storage.
    fbba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Current word: RAM data once written, reset contents before that.
    assign word_cur    = rd_valid_reg ? rd_data : reset_word(addr_reg);
    assign in_range    = {{(32 - INDEX_W){1'b0}}, idx_reg} < 32'(MAP_BLOCKS);
    assign bit_sel     = ~idx_reg[BIT_W-1:0];
    assign cur_bit     = word_cur[bit_sel] & in_range;
    assign free_pos    = first_free(word_cur);
    assign word_any    = |word_cur;
    assign last_word   = addr_reg == waddr_t'(NUM_WORDS - 1);
    assign hint_full   = hint_reg == hint_t'(NUM_WORDS);
    assign toggle_mask = word_t'(1) << bit_sel;
    assign alloc_mask  = word_t'(1) << ~free_pos;

    // Sequencer: next state, RAM control and result.
    always_comb
    begin
        state_next  = state_reg;
        hint_next   = hint_reg;
        req_next    = req_reg;
        idx_next    = idx_reg;
        addr_next   = addr_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        free_next   = free_reg;
        status_next = status_reg;
        rd_addr     = addr_reg;
        wr_en       = 1'b0;
        wr_data     = word_cur ^ toggle_mask;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = req_type;
                    idx_next = block_index;
                    if (req_type == REQ_ALLOC)
                    begin
                        addr_next = waddr_t'(hint_reg);
                    end
                    else
                    begin
                        addr_next = waddr_t'(block_index >> BIT_W);
                    end
                    rd_addr    = addr_next;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (req_reg == REQ_ALLOC)
                begin
                    if (hint_full || (!word_any && last_word))
                    begin
                        // No free block anywhere in the map.
                        done_next   = 1'b1;
                        result_next = '0;
                        free_next   = 1'b0;
                        status_next = 1'b1;
                        hint_next   = hint_t'(NUM_WORDS);
                        state_next  = ST_IDLE;
                    end
                    else if (word_any)
                    begin
                        // Claim the first free block of this word.
                        wr_en       = 1'b1;
                        wr_data     = word_cur & ~alloc_mask;
                        done_next   = 1'b1;
                        result_next = index_t'({addr_reg, free_pos});
                        free_next   = 1'b1;
                        status_next = 1'b0;
                        hint_next   = hint_t'(addr_reg);
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        // Word fully used: read the next one.
                        addr_next = addr_reg + waddr_t'(1);
                        rd_addr   = addr_next;
                    end
                end
                else
                begin
                    done_next   = 1'b1;
                    result_next = idx_reg;
                    free_next   = cur_bit;
                    status_next = 1'b0;
                    if ((req_reg == REQ_TOGGLE) && in_range)
                    begin
                        wr_en = 1'b1;
                        // A block freed below the hint moves the hint down.
                        if (!cur_bit && (hint_reg > hint_t'(addr_reg)))
                        begin
                            hint_next = hint_t'(addr_reg);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            hint_reg     <= '0;
            done_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            hint_reg     <= hint_next;
            done_reg     <= done_next;
            rd_valid_reg <= valid_reg[rd_addr];
            if (wr_en)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        addr_reg   <= addr_next;
        result_reg <= result_next;
        free_reg   <= free_next;
        status_reg <= status_next;
    end

    assign busy         = state_reg != ST_IDLE;
    assign done         = done_reg;
    assign result_block = result_reg;
    assign is_free      = free_reg;
    assign status       = status_reg;

    // A result strobe always finds the sequencer back in idle.
    `FBBA_ASSERT_SAME(a_done_idle, clk, rst_n, done_reg, !busy)
    // An accepted word starts a scan in the next cycle.
    `FBBA_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    // A full report carries block 0 and a used flag.
    `FBBA_ASSERT_SAME(a_full_zero, clk, rst_n, done_reg && status_reg, (result_reg == '0) && !free_reg)
    // The scan start point never runs past the end of the map.
    `FBBA_ASSERT_SAME(a_hint_bound, clk, rst_n, 1'b1, hint_reg <= hint_t'(NUM_WORDS))

endmodule
